// ----- hdl/i2cm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types, phase codes and sizes for the I2C master byte-transfer core.
// ---------------------------------------------------------------------------
package i2cm_pkg;

  localparam int COUNT_BITS = 8;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_START     = 4'd1;
  localparam logic [3:0] PH_ADDR      = 4'd2;
  localparam logic [3:0] PH_ADDR_ACK  = 4'd3;
  localparam logic [3:0] PH_WDATA     = 4'd4;
  localparam logic [3:0] PH_WDATA_ACK = 4'd5;
  localparam logic [3:0] PH_RDATA     = 4'd6;
  localparam logic [3:0] PH_MACK      = 4'd7;
  localparam logic [3:0] PH_STOP      = 4'd8;

  localparam logic       CMD_BEGIN    = 1'b0;
  localparam logic       CMD_TICK     = 1'b1;

  localparam logic [7:0] NACK_BYTE    = 8'h80;
  localparam logic [7:0] ADDR_MASK    = 8'hFE;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [3:0]            phase;
    logic [1:0]            step_in_bit;
    logic [3:0]            bit_index;
    logic [7:0]            shift_reg;
    logic [COUNT_BITS-1:0] bytes_left;
    logic                  is_read;
    logic                  scl_level;
    logic                  sda_level;
    logic                  failed;
  } i2cm_state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       tx_taken;
    logic       done_res;
    logic       success;
    logic       busy_res;
  } i2cm_result_t;

endpackage

// ----- hdl/i2cm_step.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_step
// One pin step: next bus state and result beat from current state and item.
// ---------------------------------------------------------------------------
module i2cm_step import i2cm_pkg::*; (
  input  i2cm_state_t  cur,
  input  logic         cmd,
  input  logic [7:0]   target_addr,
  input  logic         read_not_write,
  input  logic [7:0]   byte_count,
  input  logic [7:0]   tx_byte,
  input  logic         sda_in,
  output i2cm_state_t  nxt,
  output i2cm_result_t res
);

  logic [COUNT_BITS-1:0] cnt_n;
  logic [COUNT_BITS-1:0] bl_dec;
  logic [7:0]            sh;
  logic [7:0]            rx_sh;
  logic [3:0]            bit_inc;

  assign cnt_n   = COUNT_BITS'(byte_count);
  assign bl_dec  = cur.bytes_left - COUNT_BITS'(1);
  assign bit_inc = cur.bit_index + 4'd1;
  assign rx_sh   = {cur.shift_reg[6:0], sda_in};
  // write data loads on the first step of each data byte
  assign sh = (cur.phase == PH_WDATA && cur.step_in_bit == 2'd0 && cur.bit_index == 4'd0)
              ? tx_byte : cur.shift_reg;

  always_comb begin
    nxt = cur;
    res = '0;
    if (cmd == CMD_BEGIN) begin
      if (cur.phase == PH_IDLE) begin
        if (read_not_write && cnt_n == '0) begin
          res.done_res = 1'b1;
        end else begin
          nxt.is_read     = read_not_write;
          nxt.bytes_left  = cnt_n;
          nxt.shift_reg   = (target_addr & ADDR_MASK) | {7'd0, read_not_write};
          nxt.failed      = 1'b0;
          nxt.phase       = PH_START;
          nxt.step_in_bit = 2'd0;
          nxt.bit_index   = 4'd0;
        end
      end
    end else begin
      unique case (cur.phase)
        PH_IDLE: ;
        PH_START: begin
          unique case (cur.step_in_bit)
            2'd0: begin nxt.scl_level = 1'b1; nxt.step_in_bit = 2'd1; end
            2'd1: begin nxt.sda_level = 1'b0; nxt.step_in_bit = 2'd2; end
            2'd2: begin nxt.scl_level = 1'b0; nxt.step_in_bit = 2'd3; end
            default: begin
              nxt.sda_level   = 1'b1;
              nxt.phase       = PH_ADDR;
              nxt.step_in_bit = 2'd0;
              nxt.bit_index   = 4'd0;
            end
          endcase
        end
        PH_ADDR, PH_WDATA, PH_MACK: begin
          if (sh != cur.shift_reg || cur.phase == PH_WDATA) begin
            nxt.shift_reg = sh;
          end
          res.tx_taken = (cur.phase == PH_WDATA && cur.step_in_bit == 2'd0 &&
                          cur.bit_index == 4'd0);
          unique case (cur.step_in_bit)
            2'd0: begin nxt.sda_level = sh[7]; nxt.step_in_bit = 2'd1; end
            2'd1: begin nxt.scl_level = 1'b1;  nxt.step_in_bit = 2'd2; end
            2'd2: begin nxt.scl_level = 1'b0;  nxt.step_in_bit = 2'd3; end
            default: begin
              nxt.sda_level   = 1'b1;
              nxt.shift_reg   = {sh[6:0], 1'b0};
              nxt.step_in_bit = 2'd0;
              if (cur.phase == PH_MACK) begin
                nxt.bytes_left = bl_dec;
                nxt.phase      = (bl_dec == '0) ? PH_STOP : PH_RDATA;
                nxt.bit_index  = 4'd0;
              end else if (bit_inc >= BITS_PER_BYTE) begin
                nxt.phase     = (cur.phase == PH_ADDR) ? PH_ADDR_ACK : PH_WDATA_ACK;
                nxt.bit_index = 4'd0;
              end else begin
                nxt.bit_index = bit_inc;
              end
            end
          endcase
        end
        PH_ADDR_ACK, PH_WDATA_ACK: begin
          if (cur.step_in_bit == 2'd0) begin
            nxt.scl_level   = 1'b1;
            nxt.step_in_bit = 2'd1;
          end else begin
            nxt.scl_level   = 1'b0;
            nxt.step_in_bit = 2'd0;
            nxt.bit_index   = 4'd0;
            if (sda_in) begin
              nxt.failed = 1'b1;
              nxt.phase  = PH_STOP;
            end else if (cur.phase == PH_ADDR_ACK) begin
              if (cur.is_read) nxt.phase = PH_RDATA;
              else nxt.phase = (cur.bytes_left == '0) ? PH_STOP : PH_WDATA;
            end else begin
              nxt.bytes_left = bl_dec;
              nxt.phase      = (bl_dec == '0) ? PH_STOP : PH_WDATA;
            end
          end
        end
        PH_RDATA: begin
          if (cur.step_in_bit == 2'd0) begin
            nxt.scl_level   = 1'b1;
            nxt.step_in_bit = 2'd1;
          end else begin
            nxt.scl_level   = 1'b0;
            nxt.step_in_bit = 2'd0;
            if (bit_inc >= BITS_PER_BYTE) begin
              res.rx_byte   = rx_sh;
              res.rx_valid  = 1'b1;
              // MSB carries the master ACK level: NACK on the last byte
              nxt.shift_reg = (cur.bytes_left == COUNT_BITS'(1)) ? NACK_BYTE : 8'd0;
              nxt.phase     = PH_MACK;
              nxt.bit_index = 4'd0;
            end else begin
              nxt.shift_reg = rx_sh;
              nxt.bit_index = bit_inc;
            end
          end
        end
        PH_STOP: begin
          unique case (cur.step_in_bit)
            2'd0: begin nxt.sda_level = 1'b0; nxt.step_in_bit = 2'd1; end
            2'd1: begin nxt.scl_level = 1'b1; nxt.step_in_bit = 2'd2; end
            default: begin
              nxt.sda_level   = 1'b1;
              res.done_res    = 1'b1;
              res.success     = ~cur.failed;
              nxt.failed      = 1'b0;
              nxt.phase       = PH_IDLE;
              nxt.step_in_bit = 2'd0;
              nxt.bit_index   = 4'd0;
            end
          endcase
        end
        default: nxt.phase = PH_IDLE;
      endcase
    end
    res.scl_out  = nxt.scl_level;
    res.sda_out  = nxt.sda_level;
    res.busy_res = (nxt.phase != PH_IDLE);
  end

endmodule

// ----- hdl/i2c_master_byte_transfer_core.sv -----
`timescale 1ns / 1ps
// A result beat appears in the cycle after its item is accepted.
// Throughput: one item per cycle; the input is taken whenever the result
// register is empty or is being drained in the same cycle.
// Reset (rst_n low, synchronous): bus state idle, SCL and SDA released,
// counters cleared, no result beat pending.
// ---------------------------------------------------------------------------
// i2c_master_byte_transfer_core
// Bit-banged I2C master: each tick beat advances the pin sequence one step.
// ---------------------------------------------------------------------------
module i2c_master_byte_transfer_core import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_target_addr,
  input  logic       in_read_not_write,
  input  logic [7:0] in_byte_count,
  input  logic [7:0] in_tx_byte,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_valid,
  output logic       out_tx_taken,
  output logic       out_done_res,
  output logic       out_success,
  output logic       out_busy_res
);

  // Bus state register: the sequencer's only memory.
  i2cm_state_t  state_r, state_nxt;
  // Result register: holds one beat until the consumer takes it.
  i2cm_result_t res_r, res_nxt;
  logic         out_valid_r;
  logic         in_fire;

  // The result register frees up in the same cycle it drains, so an item
  // can enter every cycle as long as the consumer keeps up.
  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  i2cm_step u_step (
    .cur            (state_r),
    .cmd            (in_cmd),
    .target_addr    (in_target_addr),
    .read_not_write (in_read_not_write),
    .byte_count     (in_byte_count),
    .tx_byte        (in_tx_byte),
    .sda_in         (in_sda_in),
    .nxt            (state_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_IDLE;
      state_r.step_in_bit <= 2'd0;
      state_r.bit_index   <= 4'd0;
      state_r.shift_reg   <= 8'd0;
      state_r.bytes_left  <= '0;
      state_r.is_read     <= 1'b0;
      state_r.scl_level   <= 1'b1;
      state_r.sda_level   <= 1'b1;
      state_r.failed      <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset; out_valid_r qualifies it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_scl_out  = res_r.scl_out;
  assign out_sda_out  = res_r.sda_out;
  assign out_rx_byte  = res_r.rx_byte;
  assign out_rx_valid = res_r.rx_valid;
  assign out_tx_taken = res_r.tx_taken;
  assign out_done_res = res_r.done_res;
  assign out_success  = res_r.success;
  assign out_busy_res = res_r.busy_res;

  // Every accepted item leaves a beat in the result register.
  a_fire_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result beat");

  // A finished transaction leaves the bus idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_nxt.done_res) |=> (state_r.phase == PH_IDLE))
    else $error("done reported while a transaction continues");

  // Success only ever comes with done.
  a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.success) |-> res_r.done_res)
    else $error("success without done");

  // A received byte is always followed by the master ACK step.
  a_rx_mack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_nxt.rx_valid) |=> (state_r.phase == PH_MACK))
    else $error("received byte not followed by master ACK");

  // Idle bus keeps both lines released.
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_IDLE) |-> (state_r.scl_level && state_r.sda_level))
    else $error("lines driven while idle");

endmodule

// ----- tb/i2c_pin_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_pin_checker
// Watches both channels of the I2C master core, predicts the pin step and
// flags of every accepted beat, and compares each result beat in order.
// ---------------------------------------------------------------------------
module i2c_pin_checker import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_target_addr,
  input  logic       in_read_not_write,
  input  logic [7:0] in_byte_count,
  input  logic [7:0] in_tx_byte,
  input  logic       in_sda_in,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_scl_out,
  input  logic       out_sda_out,
  input  logic [7:0] out_rx_byte,
  input  logic       out_rx_valid,
  input  logic       out_tx_taken,
  input  logic       out_done_res,
  input  logic       out_success,
  input  logic       out_busy_res,
  output int         mismatches,
  output int         outstanding
);

  // bus sequencer shadow
  logic [3:0]            bus_phase;
  logic [1:0]            bit_step;
  logic [3:0]            bit_count;
  logic [7:0]            shifter;
  logic [COUNT_BITS-1:0] bytes_to_go;
  logic                  reading;
  logic                  scl_drv;
  logic                  sda_drv;
  logic                  nack_seen;

  i2cm_result_t expected_pins[$];

  function automatic void enter_phase(input logic [3:0] next);
    bus_phase = next;
    bit_step  = 2'd0;
    bit_count = 4'd0;
  endfunction

  // one step of a sent bit; high when the bit is complete
  function automatic logic send_bit_step();
    logic fin;
    fin = 1'b0;
    case (bit_step)
      2'd0: begin
        sda_drv  = shifter[7];
        bit_step = 2'd1;
      end
      2'd1: begin
        scl_drv  = 1'b1;
        bit_step = 2'd2;
      end
      2'd2: begin
        scl_drv  = 1'b0;
        bit_step = 2'd3;
      end
      default: begin
        sda_drv  = 1'b1;
        shifter  = {shifter[6:0], 1'b0};
        bit_step = 2'd0;
        fin      = 1'b1;
      end
    endcase
    return fin;
  endfunction

  // one step of a received bit; high on the SCL-lowering step
  function automatic logic recv_bit_step();
    if (bit_step == 2'd0) begin
      scl_drv  = 1'b1;
      bit_step = 2'd1;
      return 1'b0;
    end
    scl_drv  = 1'b0;
    bit_step = 2'd0;
    return 1'b1;
  endfunction

  function automatic i2cm_result_t predict_pin_step(input logic cmd, input logic [7:0] addr,
                                                    input logic rnw, input logic [7:0] cnt,
                                                    input logic [7:0] txb, input logic sdi);
    i2cm_result_t          r;
    logic [COUNT_BITS-1:0] n;
    r = '0;
    if (cmd == CMD_BEGIN) begin
      if (bus_phase == PH_IDLE) begin
        n = COUNT_BITS'(cnt);
        if (rnw && n == 0) begin
          r.done_res = 1'b1;
        end else begin
          reading     = rnw;
          bytes_to_go = n;
          shifter     = (addr & ADDR_MASK) | {7'd0, rnw};
          nack_seen   = 1'b0;
          enter_phase(PH_START);
        end
      end
    end else begin
      case (bus_phase)
        PH_START: begin
          case (bit_step)
            2'd0: begin
              scl_drv  = 1'b1;
              bit_step = 2'd1;
            end
            2'd1: begin
              sda_drv  = 1'b0;
              bit_step = 2'd2;
            end
            2'd2: begin
              scl_drv  = 1'b0;
              bit_step = 2'd3;
            end
            default: begin
              sda_drv = 1'b1;
              enter_phase(PH_ADDR);
            end
          endcase
        end
        PH_ADDR, PH_WDATA: begin
          if (bus_phase == PH_WDATA && bit_step == 2'd0 && bit_count == 4'd0) begin
            shifter    = txb;
            r.tx_taken = 1'b1;
          end
          if (send_bit_step()) begin
            bit_count = bit_count + 4'd1;
            if (bit_count >= BITS_PER_BYTE)
              enter_phase(bus_phase == PH_ADDR ? PH_ADDR_ACK : PH_WDATA_ACK);
          end
        end
        PH_ADDR_ACK, PH_WDATA_ACK: begin
          if (recv_bit_step()) begin
            if (sdi) begin
              nack_seen = 1'b1;
              enter_phase(PH_STOP);
            end else if (bus_phase == PH_ADDR_ACK) begin
              if (reading)
                enter_phase(PH_RDATA);
              else
                enter_phase(bytes_to_go == 0 ? PH_STOP : PH_WDATA);
            end else begin
              bytes_to_go = bytes_to_go - COUNT_BITS'(1);
              enter_phase(bytes_to_go == 0 ? PH_STOP : PH_WDATA);
            end
          end
        end
        PH_RDATA: begin
          if (recv_bit_step()) begin
            shifter   = {shifter[6:0], sdi};
            bit_count = bit_count + 4'd1;
            if (bit_count >= BITS_PER_BYTE) begin
              r.rx_byte  = shifter;
              r.rx_valid = 1'b1;
              // MSB holds the master ACK level, NACK on the last byte
              shifter = (bytes_to_go == 1) ? NACK_BYTE : 8'h00;
              enter_phase(PH_MACK);
            end
          end
        end
        PH_MACK: begin
          if (send_bit_step()) begin
            bytes_to_go = bytes_to_go - COUNT_BITS'(1);
            enter_phase(bytes_to_go == 0 ? PH_STOP : PH_RDATA);
          end
        end
        PH_STOP: begin
          case (bit_step)
            2'd0: begin
              sda_drv  = 1'b0;
              bit_step = 2'd1;
            end
            2'd1: begin
              scl_drv  = 1'b1;
              bit_step = 2'd2;
            end
            default: begin
              sda_drv   = 1'b1;
              r.done_res = 1'b1;
              r.success = !nack_seen;
              nack_seen = 1'b0;
              enter_phase(PH_IDLE);
            end
          endcase
        end
        default: bus_phase = PH_IDLE;
      endcase
    end
    r.scl_out  = scl_drv;
    r.sda_out  = sda_drv;
    r.busy_res = (bus_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    i2cm_result_t want;
    if (!rst_n) begin
      bus_phase   = PH_IDLE;
      bit_step    = 2'd0;
      bit_count   = 4'd0;
      shifter     = 8'h00;
      bytes_to_go = '0;
      reading     = 1'b0;
      scl_drv     = 1'b1;
      sda_drv     = 1'b1;
      nack_seen   = 1'b0;
      expected_pins.delete();
    end else begin
      // drain first: a result beat this edge belongs to an earlier item
      if (out_valid && out_ready) begin
        if (expected_pins.size() == 0) begin
          $display("%0t: result beat with none expected, actual scl %0b sda %0b", $time,
                   out_scl_out, out_sda_out);
          mismatches++;
        end else begin
          want = expected_pins.pop_front();
          compare_field("scl_out", want.scl_out, out_scl_out);
          compare_field("sda_out", want.sda_out, out_sda_out);
          compare_field("rx_byte", want.rx_byte, out_rx_byte);
          compare_field("rx_valid", want.rx_valid, out_rx_valid);
          compare_field("tx_taken", want.tx_taken, out_tx_taken);
          compare_field("done_res", want.done_res, out_done_res);
          compare_field("success", want.success, out_success);
          compare_field("busy_res", want.busy_res, out_busy_res);
        end
      end
      if (in_valid && in_ready)
        expected_pins.push_back(predict_pin_step(in_cmd, in_target_addr, in_read_not_write,
                                                 in_byte_count, in_tx_byte, in_sda_in));
    end
    outstanding = expected_pins.size();
  end

endmodule

// ----- tb/i2c_master_byte_transfer_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_master_byte_transfer_core_test
// Drives whole I2C transactions into the master core one pin-step beat at a
// time, with random slave data, NACKs and ignored beats mixed in, under
// varying backpressure; a side checker predicts and compares every result.
// ---------------------------------------------------------------------------
module i2c_master_byte_transfer_core_test import i2cm_pkg::*;;

  // Tick numbers within one transaction, counted from the first tick after
  // the begin beat: START takes 4 ticks and the address byte 32, so the
  // slave ACK of the address is sampled on tick 38. Each write byte adds
  // 32 send ticks plus 2 ACK ticks; each read byte 16 receive ticks plus a
  // 4-tick master ACK. STOP is 3 ticks.
  localparam int ACK_TICK     = 38;
  localparam int WBYTE_TICKS  = 34;
  localparam int RBYTE_TICKS  = 20;
  localparam int STOP_TICKS   = 3;

  localparam int PHASE_BEATS  = 470;     // counted beats per backpressure phase
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run

  logic       clk;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic       in_cmd            = CMD_TICK;
  logic [7:0] in_target_addr    = 8'h00;
  logic       in_read_not_write = 1'b0;
  logic [7:0] in_byte_count     = 8'h00;
  logic [7:0] in_tx_byte        = 8'h00;
  logic       in_sda_in         = 1'b1;
  logic       out_valid;
  logic       out_ready         = 1'b0;
  logic       out_scl_out;
  logic       out_sda_out;
  logic [7:0] out_rx_byte;
  logic       out_rx_valid;
  logic       out_tx_taken;
  logic       out_done_res;
  logic       out_success;
  logic       out_busy_res;

  int mismatches;
  int outstanding;

  // idle rates in percent, changed per phase by the stimulus
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  // beats that move the bus; ignored noise beats are not counted
  int beats_sent   = 0;

  i2c_master_byte_transfer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_target_addr    (in_target_addr),
    .in_read_not_write (in_read_not_write),
    .in_byte_count     (in_byte_count),
    .in_tx_byte        (in_tx_byte),
    .in_sda_in         (in_sda_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_out       (out_scl_out),
    .out_sda_out       (out_sda_out),
    .out_rx_byte       (out_rx_byte),
    .out_rx_valid      (out_rx_valid),
    .out_tx_taken      (out_tx_taken),
    .out_done_res      (out_done_res),
    .out_success       (out_success),
    .out_busy_res      (out_busy_res)
  );

  i2c_pin_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_target_addr    (in_target_addr),
    .in_read_not_write (in_read_not_write),
    .in_byte_count     (in_byte_count),
    .in_tx_byte        (in_tx_byte),
    .in_sda_in         (in_sda_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_out       (out_scl_out),
    .out_sda_out       (out_sda_out),
    .out_rx_byte       (out_rx_byte),
    .out_rx_valid      (out_rx_valid),
    .out_tx_taken      (out_tx_taken),
    .out_done_res      (out_done_res),
    .out_success       (out_success),
    .out_busy_res      (out_busy_res),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver side: ready is redrawn every edge, so stalls land on every
  // step of the bus sequence.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Hard stop if the handshake ever hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Present one beat and hold it until accepted. Called right after a
  // rising edge; ready is sampled at the falling edge, where nothing the
  // bench drives can still move it before the next rising edge.
  task automatic put_beat(input logic cmd, input logic [7:0] addr, input logic rnw,
                          input logic [7:0] cnt, input logic [7:0] txb, input logic sdi);
    logic hs;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_target_addr    <= addr;
    in_read_not_write <= rnw;
    in_byte_count     <= cnt;
    in_tx_byte        <= txb;
    in_sda_in         <= sdi;
    do begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
    end while (!hs);
  endtask

  // Tick with no transaction running: no pin moves, all flags low.
  task automatic put_idle_tick();
    put_beat(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
             8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // One full transaction: a begin beat, then exactly as many ticks as the
  // bus needs to get through STOP. nack_at picks the slave ACK slot that answers
  // NACK (0 = address, k = write byte k), or -1 for a clean run. Slave
  // data bits on a read, and SDA on steps that are not sampled, are random.
  task automatic run_transfer(input logic rnw, input int count, input int nack_at);
    int   total;
    logic sdi;
    put_beat(CMD_BEGIN, 8'($urandom_range(255)), rnw, 8'(count), 8'($urandom_range(255)),
             1'($urandom_range(1)));
    beats_sent++;
    // a zero-length read finishes on its begin beat
    if (rnw && count == 0)
      return;
    if (rnw)
      total = ACK_TICK + ((nack_at == 0) ? 0 : RBYTE_TICKS * count) + STOP_TICKS;
    else
      total = ACK_TICK + WBYTE_TICKS * ((nack_at >= 0) ? nack_at : count) + STOP_TICKS;
    for (int t = 1; t <= total; t++) begin
      // stray begin in mid-transaction: must be ignored
      if ($urandom_range(99) < 3)
        put_beat(CMD_BEGIN, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      if (t >= ACK_TICK && (t - ACK_TICK) % WBYTE_TICKS == 0 && (!rnw || t == ACK_TICK))
        sdi = ((t - ACK_TICK) / WBYTE_TICKS == nack_at);
      else
        sdi = 1'($urandom_range(1));
      put_beat(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
               8'($urandom_range(255)), 8'($urandom_range(255)), sdi);
      beats_sent++;
    end
  endtask

  // Mostly short transfers so many transactions fit; about one in five
  // gets a slave NACK somewhere.
  task automatic run_random_transfer();
    logic rnw;
    int   count;
    int   pick;
    int   nack_at;
    rnw  = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 15)
      count = 0;
    else if (pick < 85)
      count = $urandom_range(3, 1);
    else if (pick < 97)
      count = $urandom_range(8, 4);
    else
      count = $urandom_range(16, 9);
    nack_at = -1;
    if ($urandom_range(99) < 20)
      nack_at = rnw ? 0 : $urandom_range(count);
    run_transfer(rnw, count, nack_at);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ticks while idle with every field at both extremes, and
    // zero-length reads that must finish at once with success low.
    put_beat(CMD_TICK, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1);
    put_beat(CMD_TICK, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    put_beat(CMD_BEGIN, 8'hFF, 1'b1, 8'h00, 8'hFF, 1'b1);
    put_beat(CMD_BEGIN, 8'h00, 1'b1, 8'h00, 8'h00, 1'b0);

    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          in_idle_pct  = 18;
          out_idle_pct = 63;
        end
        1: begin
          in_idle_pct  = 63;
          out_idle_pct = 18;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase

      if (stage == 0) begin
        // one of each flavor early on, random content
        run_transfer(1'b0, 0, -1);  // zero-length write: START, address, STOP
        run_transfer(1'b0, 2, 0);   // address NACK
        run_transfer(1'b0, 2, 2);   // NACK on the last write byte
        run_transfer(1'b0, 2, -1);
        run_transfer(1'b1, 1, -1);  // single read byte, master NACKs it
        run_transfer(1'b1, 3, 0);   // read with address NACK
      end
      if (stage == 2) begin
        // largest count: top bit of the counter, cut short by a NACK
        run_transfer(1'b0, 255, 2);
        run_transfer(1'b1, 255, 0);
        run_transfer(1'b1, 128, 0);
      end

      while (beats_sent < (stage + 1) * PHASE_BEATS) begin
        if ($urandom_range(99) < 10)
          put_idle_tick();
        run_random_transfer();
      end
    end

    in_valid <= 1'b0;

    // let every predicted beat drain, then keep watching for strays
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
